// ----- rtl/core/itr_pkg.sv -----
// Shared types, constants and the digit-to-ASCII function for the radix text converter.
package itr_pkg;

	localparam int BASE_W    = 6;
	localparam int CHAR_W    = 7;
	localparam int MAX_CHARS = 32;
	localparam int IDX_W     = $clog2(MAX_CHARS);
	localparam int CNT_W     = IDX_W + 1;
	localparam int BITS_PER_CYCLE = 8;

	localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
	localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
	localparam logic [BASE_W-1:0] DIGIT_MAX_DEC = 6'd9;
	localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

	typedef struct packed {
		logic load;
		logic div_step;
		logic store_digit;
		logic store_minus;
		logic emit_load;
	} itr_cmd_t;

	typedef struct packed {
		logic div_last;
		logic quot_zero;
		logic cnt_last;
		logic buf_full;
		logic neg;
		logic emit_last;
		logic out_free;
	} itr_stat_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d > DIGIT_MAX_DEC) begin
			c = CHAR_A + CHAR_W'(d - BASE_DEC);
		end else begin
			c = CHAR_ZERO + CHAR_W'(d);
		end
		return c;
	endfunction

endpackage

// ----- rtl/core/itr_value_if.sv -----
// Input channel carrying one integer per beat.
interface itr_value_if #(
	parameter int WIDTH = 32
);
	logic                    valid;
	logic                    ready;
	logic signed [WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

// ----- rtl/core/itr_text_if.sv -----
// Output channel carrying one ASCII character per beat with an end flag.
interface itr_text_if;
	logic       valid;
	logic       ready;
	logic [6:0] character;
	logic       last_char;

	modport source (output valid, output character, output last_char, input ready);
	modport sink   (input valid, input character, input last_char, output ready);
endinterface

// ----- rtl/core/itr_cfg_if.sv -----
// Configuration write channel carrying the number base.
interface itr_cfg_if;
	logic       valid;
	logic       ready;
	logic [5:0] number_base;

	modport source (output valid, output number_base, input ready);
	modport sink   (input valid, input number_base, output ready);
endinterface

// ----- rtl/core/itr_ctrl.sv -----
// Sequencer that steps the converter through load, divide, store, sign and emit.
module itr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  itr_pkg::itr_stat_t stat,
	output itr_pkg::itr_cmd_t  cmd
);
	import itr_pkg::*;

	typedef enum logic [2:0] {
		IDLE,
		DIV,
		STORE,
		SIGN,
		EMIT
	} state_t;

	state_t state_q;
	logic   in_ready_q;

	assign in_ready = in_ready_q;

	always_comb begin
		cmd             = '0;
		cmd.load        = (state_q == IDLE) && in_valid && in_ready_q;
		cmd.div_step    = (state_q == DIV);
		cmd.store_digit = (state_q == STORE);
		cmd.store_minus = (state_q == SIGN);
		cmd.emit_load   = (state_q == EMIT) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			in_ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= DIV;
						in_ready_q <= 1'b0;
					end
				end
				DIV: begin
					if (stat.div_last) begin
						state_q <= STORE;
					end
				end
				STORE: begin
					if (stat.quot_zero || stat.cnt_last) begin
						state_q <= stat.neg ? SIGN : EMIT;
					end else begin
						state_q <= DIV;
					end
				end
				SIGN: begin
					state_q <= EMIT;
				end
				EMIT: begin
					if (stat.out_free && stat.emit_last) begin
						state_q    <= IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end
endmodule

// ----- rtl/core/itr_dpath.sv -----
// Datapath: base register, digit divider, character buffer and output register.
module itr_dpath #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr,
	input  logic [itr_pkg::BASE_W-1:0]    cfg_base,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  itr_pkg::itr_cmd_t             cmd,
	output itr_pkg::itr_stat_t            stat,
	output logic [itr_pkg::CHAR_W-1:0]    out_char,
	output logic                          out_last,
	output logic                          out_valid,
	input  logic                          out_ready
);
	import itr_pkg::*;

	localparam int NSTEP  = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
	localparam int QW     = NSTEP * BITS_PER_CYCLE;
	localparam int STEP_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;

	logic [BASE_W-1:0]   base_cfg_q;
	logic [BASE_W-1:0]   div_base_q;
	logic                neg_q;
	logic [QW-1:0]       quot_q;
	logic [BASE_W-1:0]   rem_q;
	logic [STEP_W-1:0]   step_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CHAR_W-1:0]   digit_buf_q [MAX_CHARS];
	logic [CHAR_W-1:0]   out_char_q;
	logic                out_last_q;
	logic                out_valid_q;

	logic [VALUE_WIDTH-1:0] v_raw;
	logic [VALUE_WIDTH-1:0] v_mag;
	logic [BASE_W-1:0]      base_eff;
	logic                   v_neg;
	logic [BASE_W-1:0]      rem_next;
	logic [BITS_PER_CYCLE-1:0] qbits;
	logic [IDX_W-1:0]       rd_idx;

	// Clamp the configured base into the range the divider supports.
	always_comb begin
		if (base_cfg_q < BASE_MIN) begin
			base_eff = BASE_MIN;
		end else if (base_cfg_q > BASE_MAX) begin
			base_eff = BASE_MAX;
		end else begin
			base_eff = base_cfg_q;
		end
	end

	assign v_raw = VALUE_WIDTH'(value);
	assign v_neg = (base_eff == BASE_DEC) && v_raw[VALUE_WIDTH-1];
	assign v_mag = v_neg ? VALUE_WIDTH'(~v_raw + VALUE_WIDTH'(1)) : v_raw;

	// Restoring division, several quotient bits per cycle; the partial
	// remainder always stays below the base, so every step is narrow.
	always_comb begin
		logic [BASE_W:0] trial;
		logic [BASE_W-1:0] r;
		r     = rem_q;
		qbits = '0;
		for (int i = 0; i < BITS_PER_CYCLE; i++) begin
			trial = {r, quot_q[QW-1-i]};
			if (trial >= {1'b0, div_base_q}) begin
				r = BASE_W'(trial - {1'b0, div_base_q});
				qbits[BITS_PER_CYCLE-1-i] = 1'b1;
			end else begin
				r = trial[BASE_W-1:0];
			end
		end
		rem_next = r;
	end

	assign rd_idx = IDX_W'(cnt_q - CNT_W'(1));

	always_comb begin
		stat           = '0;
		stat.div_last  = (step_q == STEP_W'(NSTEP - 1));
		stat.quot_zero = (quot_q == '0);
		stat.cnt_last  = (cnt_q == CNT_W'(MAX_CHARS - 1));
		stat.buf_full  = (cnt_q == CNT_W'(MAX_CHARS));
		stat.neg       = neg_q;
		stat.emit_last = (cnt_q == CNT_W'(1));
		stat.out_free  = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_cfg_q  <= BASE_RESET;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				base_cfg_q <= cfg_base;
			end
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.store_digit || cmd.store_minus) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.emit_load) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			div_base_q <= base_eff;
			neg_q      <= v_neg;
			quot_q     <= QW'(v_mag);
			rem_q      <= '0;
			step_q     <= '0;
		end else if (cmd.div_step) begin
			quot_q <= (quot_q << BITS_PER_CYCLE) | QW'(qbits);
			rem_q  <= rem_next;
			step_q <= step_q + STEP_W'(1);
		end else if (cmd.store_digit) begin
			rem_q  <= '0;
			step_q <= '0;
		end
		if (cmd.store_digit) begin
			digit_buf_q[cnt_q[IDX_W-1:0]] <= digit_char(rem_q);
		end else if (cmd.store_minus) begin
			digit_buf_q[cnt_q[IDX_W-1:0]] <= CHAR_MINUS;
		end
		if (cmd.emit_load) begin
			out_char_q <= digit_buf_q[rd_idx];
			out_last_q <= (cnt_q == CNT_W'(1));
		end
	end

	assign out_char  = out_char_q;
	assign out_last  = out_last_q;
	assign out_valid = out_valid_q;
endmodule

// ----- rtl/core/integer_to_radix_text.sv -----
// Top level of the integer to radix text converter.
//
//   Channel    Dir   Beat payload                  Meaning
//   value_ch   in    value [VALUE_WIDTH]           one integer to convert
//   text_ch    out   character [7], last_char [1]  one ASCII character of the text
//   base_cfg   in    number_base [6]               radix; the user writes it only while idle (not enforced)
//
// An item has at least one digit. For every digit the shared digit divider
// retires eight quotient bits per cycle and the remainder is then stored as a
// character; a negative value in base 10 then gets a minus sign, and the
// character buffer delivers one character per cycle while the output is not
// stalled, until the last character sits in the output register.
// Reset clears the sequencer, the output valid and sets the base to ten.
// A stalled output only holds the emit sequence; the next value is taken as
// soon as the last character has moved into the output register.
module integer_to_radix_text #(
	parameter int VALUE_WIDTH = 32
) (
	input logic     clk,
	input logic     arst_n,
	itr_value_if.sink  value_ch,
	itr_text_if.source text_ch,
	itr_cfg_if.sink    base_cfg
);
	import itr_pkg::*;

	itr_cmd_t  cmd;
	itr_stat_t stat;

	// The base register takes a write in any cycle; the user writes it only while idle (not enforced).
	assign base_cfg.ready = 1'b1;

	// The sequencer owns the input handshake and issues at most one command per cycle.
	itr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (value_ch.valid),
		.in_ready (value_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath divides, buffers characters least significant first and
	// replays them in reverse through its output register.
	itr_dpath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (base_cfg.valid),
		.cfg_base  (base_cfg.number_base),
		.value     (value_ch.value),
		.cmd       (cmd),
		.stat      (stat),
		.out_char  (text_ch.character),
		.out_last  (text_ch.last_char),
		.out_valid (text_ch.valid),
		.out_ready (text_ch.ready)
	);

	// Emission never overlaps with taking a new value.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |-> !value_ch.ready)
		else $error("character emitted while input is open");

	// A character is only loaded when the output register is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |-> stat.out_free)
		else $error("output register overwritten");

	// The buffer never overflows.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.store_digit || cmd.store_minus) |-> !stat.buf_full)
		else $error("character buffer overflow");

	// In the cycle after the final beat of a text the output is empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		(text_ch.valid && text_ch.ready && text_ch.last_char) |=> !text_ch.valid)
		else $error("character after final beat");
endmodule
